// ----- rtl/sitd_pkg.sv -----
// Shared constants and types for the signed integer to decimal text block.
// Used by the top level and by the divide-by-ten unit; no dependencies.
package sitd_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_MAX_DIGITS  = 10;
    localparam int LEN_W           = 16;
    localparam int CH_W            = 8;
    localparam int DIG_W           = 4;
    localparam int DIV_STEP        = 8;

    localparam logic [DIG_W:0]  DIV_BASE = 5'd10;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic             done;
        logic [DIG_W-1:0] rem;
    } t_div_sts;

endpackage

// ----- rtl/sitd_div10.sv -----
// Iterative divide-by-ten unit: shift-subtract, eight quotient bits per cycle.
// Depends on sitd_pkg.
module sitd_div10 import sitd_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    output logic [VALUE_WIDTH-1:0] o_quo,
    output t_div_sts               o_sts
);

    localparam int PAD_W   = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int NSTEP   = PAD_W / DIV_STEP;
    localparam int STEP_CW = $clog2(NSTEP + 1);

    logic [PAD_W-1:0]   r_quo, n_quo;
    logic [DIG_W-1:0]   r_rem, n_rem;
    logic [STEP_CW-1:0] r_left;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        logic [DIG_W:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int j = 0; j < DIV_STEP; j++) begin
            t = {n_rem, n_quo[PAD_W-1]};
            if (t >= DIV_BASE) begin
                n_rem = DIG_W'(t - DIV_BASE);
                n_quo = {n_quo[PAD_W-2:0], 1'b1};
            end else begin
                n_rem = t[DIG_W-1:0];
                n_quo = {n_quo[PAD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= STEP_CW'(NSTEP);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == STEP_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= PAD_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quo      = r_quo[VALUE_WIDTH-1:0];
    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

endmodule

// ----- rtl/signed_int_to_decimal_ascii_top.sv -----
// Signed integer to decimal ASCII text: sequencer, digit store and output register.
// Depends on sitd_pkg and sitd_div10.
//
// One value is taken at a time; the input stalls until its terminator has
// entered the output register. Each digit runs through the shared divide-by-ten
// unit, which retires eight quotient bits per cycle. Characters then leave one
// per cycle while the output is not stalled: an optional '-', the digits most
// significant first, and a terminator that carries the new remaining length.
module signed_int_to_decimal_ascii_top import sitd_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic signed [LEN_W-1:0]       i_max_len,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [CH_W-1:0]               o_ch,
    output logic                          o_ch_valid,
    output logic                          o_last,
    output logic signed [LEN_W-1:0]       o_remaining
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CHK  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_sign, n_sign;
    logic                     r_term, n_term;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic signed [LEN_W-1:0]  r_len, n_len;
    logic [VALUE_WIDTH-1:0]   r_mag, n_mag;
    logic                     r_out_valid, n_out_valid;
    logic [CH_W-1:0]          r_ch, n_ch;
    logic                     r_ch_valid, n_ch_valid;
    logic                     r_last, n_last;
    logic signed [LEN_W-1:0]  r_rem_out, n_rem_out;
    logic [DIG_W-1:0]         r_store [MAX_DIGITS];

    logic                     w_div_start;
    logic [VALUE_WIDTH-1:0]   w_quo;
    t_div_sts                 w_div;
    logic                     w_st_we;
    logic [IDX_W-1:0]         w_st_idx;
    logic [DIG_W-1:0]         w_st_wd;
    logic [CNT_W-1:0]         w_idx_m1;
    logic                     w_dig_pick;
    logic [VALUE_WIDTH-1:0]   w_neg_mag;
    logic                     w_out_free;

    sitd_div10 #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .o_quo      (w_quo),
        .o_sts      (w_div)
    );

    assign w_neg_mag  = ~i_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    assign w_idx_m1   = r_idx - 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_sign      = r_sign;
        n_term      = r_term;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_len       = r_len;
        n_mag       = r_mag;
        n_out_valid = r_out_valid && i_out_stall;
        n_ch        = r_ch;
        n_ch_valid  = r_ch_valid;
        n_last      = r_last;
        n_rem_out   = r_rem_out;
        w_div_start = 1'b0;
        w_st_we     = 1'b0;
        w_st_idx    = r_cnt[IDX_W-1:0];
        w_st_wd     = '0;
        w_dig_pick  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt  = '0;
                    n_idx  = '0;
                    n_sign = 1'b0;
                    n_term = 1'b1;
                    if (i_max_len < 16'sd1) begin
                        n_term  = 1'b0;
                        n_len   = i_max_len;
                        n_state = S_EMIT;
                    end else if (i_value[VALUE_WIDTH-1]) begin
                        n_sign  = 1'b1;
                        n_len   = i_max_len - 16'sd1;
                        n_mag   = w_neg_mag;
                        n_state = S_CHK;
                    end else if (i_value == '0 && i_max_len > 16'sd1) begin
                        w_st_we  = 1'b1;
                        w_st_idx = '0;
                        n_cnt    = CNT_W'(1);
                        n_idx    = CNT_W'(1);
                        n_len    = i_max_len - 16'sd2;
                        n_state  = S_EMIT;
                    end else begin
                        n_len   = i_max_len;
                        n_mag   = i_value;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (r_len > 16'sd1 && r_mag != '0 && r_cnt < CNT_W'(MAX_DIGITS)) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_idx   = r_cnt;
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_st_we = 1'b1;
                    w_st_wd = w_div.rem;
                    n_mag   = w_quo;
                    n_cnt   = r_cnt + 1'b1;
                    n_len   = r_len - 16'sd1;
                    n_state = S_CHK;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ch_valid  = 1'b1;
                    n_last      = 1'b0;
                    n_rem_out   = '0;
                    if (r_sign) begin
                        n_ch   = CH_MINUS;
                        n_sign = 1'b0;
                    end else if (r_idx != '0) begin
                        w_dig_pick = 1'b1;
                        n_idx      = w_idx_m1;
                    end else begin
                        n_ch       = CH_NUL;
                        n_ch_valid = r_term;
                        n_last     = 1'b1;
                        n_rem_out  = r_len;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_mag       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_mag       <= n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sign     <= n_sign;
        r_term     <= n_term;
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_ch_valid <= n_ch_valid;
        r_last     <= n_last;
        r_rem_out  <= n_rem_out;
        if (w_dig_pick) begin
            r_ch <= CH_ZERO | CH_W'(r_store[w_idx_m1[IDX_W-1:0]]);
        end else begin
            r_ch <= n_ch;
        end
        if (w_st_we) begin
            r_store[w_st_idx] <= w_st_wd;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ch        = r_ch;
    assign o_ch_valid  = r_ch_valid;
    assign o_last      = r_last;
    assign o_remaining = r_rem_out;

endmodule

// ----- rtl/sitd_checker.sv -----
// Port-level checks for the signed integer to decimal text block, bound to the top.
// Depends on sitd_pkg.
module sitd_checker import sitd_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [CH_W-1:0]         o_ch,
    input logic                    o_ch_valid,
    input logic                    o_last,
    input logic signed [LEN_W-1:0] o_remaining
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_ch) && $stable(o_last) && $stable(o_remaining))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before conversion finished");

    a_rem_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_remaining == '0)
        else $error("remaining length nonzero on non-final item");

    a_unwritten_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ch_valid |-> o_last && o_ch == CH_NUL)
        else $error("unwritten item is not a lone final terminator");

endmodule

bind signed_int_to_decimal_ascii_top sitd_checker u_sitd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_ch        (o_ch),
    .o_ch_valid  (o_ch_valid),
    .o_last      (o_last),
    .o_remaining (o_remaining)
);

// ----- tb/signed_int_to_decimal_ascii_checker.sv -----
`timescale 1ns / 100ps
// Checker for signed_int_to_decimal_ascii_top: predicts the decimal text of each
// accepted value and compares every output character against it.
// Depends on sitd_pkg.
module signed_int_to_decimal_ascii_checker import sitd_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [DEF_VALUE_WIDTH-1:0] i_value,
    input  logic signed [LEN_W-1:0]           i_max_len,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [CH_W-1:0]                   i_ch,
    input  logic                              i_ch_valid,
    input  logic                              i_last,
    input  logic signed [LEN_W-1:0]           i_remaining,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int unsigned RADIX       = 10;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [CH_W-1:0]         ch;
        logic                    written;
        logic                    last;
        logic signed [LEN_W-1:0] remaining;
    } t_text_char;

    t_text_char expected_text[$];
    int         fail_count    = 0;
    int         pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void push_char(input logic [CH_W-1:0] ch, input logic written,
                                      input logic last, input int remaining);
        t_text_char c;
        c.ch        = ch;
        c.written   = written;
        c.last      = last;
        c.remaining = LEN_W'(remaining);
        expected_text.push_back(c);
    endfunction

    function automatic void predict_text(input logic signed [DEF_VALUE_WIDTH-1:0] value,
                                         input logic signed [LEN_W-1:0] max_len);
        logic [DEF_VALUE_WIDTH-1:0] magnitude;
        logic [DIG_W-1:0]           digits [DEF_MAX_DIGITS];
        int                         room;
        int                         count;
        room  = max_len;
        count = 0;
        if (room < 1) begin
            push_char(CH_NUL, 1'b0, 1'b1, room);
            return;
        end
        if (value[DEF_VALUE_WIDTH-1]) begin
            magnitude = ~value + 1'b1;
            push_char(CH_MINUS, 1'b1, 1'b0, 0);
            room = room - 1;
        end else begin
            magnitude = value;
            if (magnitude == 0 && room > 1) begin
                push_char(CH_ZERO, 1'b1, 1'b0, 0);
                push_char(CH_NUL, 1'b1, 1'b1, room - 2);
                return;
            end
        end
        while (room > 1 && magnitude > 0 && count < DEF_MAX_DIGITS) begin
            digits[count] = DIG_W'(magnitude % RADIX);
            magnitude     = magnitude / RADIX;
            count         = count + 1;
            room          = room - 1;
        end
        for (int i = count - 1; i >= 0; i--)
            push_char(CH_ZERO + CH_W'(digits[i]), 1'b1, 1'b0, 0);
        push_char(CH_NUL, 1'b1, 1'b1, room);
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                predict_text(i_value, i_max_len);
            if (i_out_valid && !i_out_stall) begin
                if (expected_text.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: unexpected item ch=%h ch_valid=%b last=%b remaining=%0d",
                                 $realtime, i_ch, i_ch_valid, i_last, i_remaining);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_text.pop_front();
                    if (i_ch !== want.ch || i_ch_valid !== want.written ||
                        i_last !== want.last || i_remaining !== want.remaining) begin
                        if (fail_count < REPORT_MAX) begin
                            $write("%0t: mismatch exp ch=%h ch_valid=%b last=%b rem=%0d",
                                   $realtime, want.ch, want.written, want.last,
                                   want.remaining);
                            $display(" got ch=%h ch_valid=%b last=%b rem=%0d",
                                     i_ch, i_ch_valid, i_last, i_remaining);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_count = expected_text.size();
        end
    end

endmodule

// ----- tb/signed_int_to_decimal_ascii_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for signed_int_to_decimal_ascii_top: clock, reset, directed and
// random values, random output stalls. Depends on sitd_pkg and the checker.
module signed_int_to_decimal_ascii_top_tb import sitd_pkg::*;;

    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic signed [DEF_VALUE_WIDTH-1:0] i_value;
    logic signed [LEN_W-1:0]           i_max_len;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [CH_W-1:0]                   o_ch;
    logic                              o_ch_valid;
    logic                              o_last;
    logic signed [LEN_W-1:0]           o_remaining;
    int                                fail_count;
    int                                pending;
    bit                                pressure_go = 1'b0;

    signed_int_to_decimal_ascii_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_max_len   (i_max_len),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ch        (o_ch),
        .o_ch_valid  (o_ch_valid),
        .o_last      (o_last),
        .o_remaining (o_remaining)
    );

    signed_int_to_decimal_ascii_checker u_text_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_max_len    (i_max_len),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_ch         (o_ch),
        .i_ch_valid   (o_ch_valid),
        .i_last       (o_last),
        .i_remaining  (o_remaining),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [DEF_VALUE_WIDTH-1:0] random_value();
        int unsigned scale;
        logic signed [DEF_VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 40) - 20;
            2: begin
                scale = 1;
                repeat ($urandom_range(0, 9)) scale = scale * 10;
                v = scale * $urandom_range(1, 2);
                if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: begin
                v = $urandom_range(0, 999999);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [LEN_W-1:0] random_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return LEN_W'($urandom_range(1, 14));
        if (roll < 85) return LEN_W'($urandom_range(15, 32767));
        return LEN_W'(-$signed($urandom_range(0, 32768)));
    endfunction

    task automatic send_value(input logic signed [DEF_VALUE_WIDTH-1:0] v,
                              input logic signed [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_max_len  <= len;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // receiver: random stall runs, one long hold once the random phase starts
    initial begin
        int  run;
        int  roll;
        bit  pressure_done;
        pressure_done = 1'b0;
        i_out_stall   = 1'b0;
        forever begin
            if (pressure_go && !pressure_done) begin
                pressure_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 50) begin
                    i_out_stall <= 1'b0;
                    run = $urandom_range(1, 20);
                end else begin
                    i_out_stall <= 1'b1;
                    if (roll < 85) run = $urandom_range(1, 3);
                    else if (roll < 97) run = $urandom_range(4, 12);
                    else run = $urandom_range(20, 60);
                end
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_value    = '0;
        i_max_len  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_value(0, 10);
        send_value(0, 2);
        send_value(0, 1);
        send_value(0, 0);
        send_value(5, -1);
        send_value(5, -32768);
        send_value(32'sh8000_0000, 20);
        send_value(32'sh7FFF_FFFF, 20);
        send_value(32'sh8000_0000, 32767);
        send_value(32'sh7FFF_FFFF, 32767);
        send_value(-1, 20);
        send_value(1, 20);
        send_value(-5, 1);
        send_value(5, 1);
        send_value(-5, 2);
        send_value(1234567, 4);
        send_value(-98765, 3);
        send_value(9, 2);
        send_value(10, 3);
        send_value(999999999, 20);
        send_value(1000000000, 11);
        send_value(1000000000, 10);
        send_value(-2147483647, 12);

        pressure_go = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_value(random_value(), random_len());
        i_in_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sitd_pkg.sv
rtl/sitd_div10.sv
rtl/signed_int_to_decimal_ascii_top.sv
rtl/sitd_checker.sv
tb/signed_int_to_decimal_ascii_checker.sv
tb/signed_int_to_decimal_ascii_top_tb.sv
